@@ hdl/pps_pkg.sv @@
package pps_pkg;

    localparam int SLOT_W      = 4;
    localparam int SLOT_COUNT  = 1 << SLOT_W;
    localparam int TIME_W      = 16;
    localparam int PRIO_W      = 8;
    localparam int NOW_W       = 32;
    localparam int ID_W        = 5;
    localparam int COST_W      = 8;
    localparam int DEFAULT_MAX_TASKS = 16;

    localparam logic [ID_W-1:0] COUNT_MAX = '1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_RAN  = 2'd1;
    localparam logic [1:0] KIND_IDLE = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_length;
        logic [PRIO_W-1:0] prio_level;
    } sched_cmd_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  task_id;
        logic [NOW_W-1:0] slice_end;
        logic             switched;
        logic             finished;
        logic [NOW_W-1:0] turnaround;
        logic [NOW_W-1:0] waiting;
        logic [NOW_W-1:0] wait_sum;
        logic [NOW_W-1:0] turnaround_sum;
        logic [ID_W-1:0]  done_count;
    } sched_result_t;

    // running best candidate handed from cell to cell during a scan
    typedef struct packed {
        logic              pending;
        logic              found;
        logic [PRIO_W-1:0] prio;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
    } cand_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              load;
        logic              dec;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
        logic [NOW_W-1:0]  now;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWITCH,
        ST_TICK,
        ST_TAT,
        ST_WAIT,
        ST_SUM
    } sched_state_t;

    function automatic logic [NOW_W-1:0] sat_add(input logic [NOW_W-1:0] a,
                                                 input logic [NOW_W-1:0] b);
        logic [NOW_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[NOW_W] ? {NOW_W{1'b1}} : s[NOW_W-1:0];
    endfunction

endpackage

@@ hdl/pps_cell.sv @@
module pps_cell #(
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pps_pkg::cell_ctl_t ctl,
    input  logic              vld_in,
    input  pps_pkg::cand_t    cand_in,
    output logic              vld_out,
    output pps_pkg::cand_t    cand_out
);
    import pps_pkg::*;

    localparam bit                ADDRESSABLE = INDEX < SLOT_COUNT;
    localparam logic [SLOT_W-1:0] MY_SLOT     = SLOT_W'(INDEX);

    logic [TIME_W-1:0] arrival_reg;
    logic [TIME_W-1:0] burst_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [TIME_W-1:0] remaining_reg;
    logic              loaded_reg;
    logic              vld_reg;
    cand_t             cand_reg;

    logic  hit;
    logic  eligible;
    logic  arrived;
    logic  take;
    cand_t cand_next;

    assign hit      = ADDRESSABLE && (ctl.slot == MY_SLOT);
    assign eligible = loaded_reg && (remaining_reg != '0);
    assign arrived  = (ctl.now[NOW_W-1:TIME_W] != '0) || (arrival_reg <= ctl.now[TIME_W-1:0]);
    // strict compare keeps the lower slot on a tie
    assign take     = eligible && arrived && (!cand_in.found || (prio_reg < cand_in.prio));

    always_comb
    begin
        cand_next         = cand_in;
        cand_next.pending = cand_in.pending | eligible;
        if (take)
        begin
            cand_next.found     = 1'b1;
            cand_next.prio      = prio_reg;
            cand_next.slot      = MY_SLOT;
            cand_next.arrival   = arrival_reg;
            cand_next.burst     = burst_reg;
            cand_next.remaining = remaining_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            loaded_reg    <= 1'b0;
            vld_reg       <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
            if (ctl.load && hit)
            begin
                remaining_reg <= ctl.burst;
                loaded_reg    <= 1'b1;
            end
            else if (ctl.dec && hit)
            begin
                remaining_reg <= remaining_reg - TIME_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        if (ctl.load && hit)
        begin
            arrival_reg <= ctl.arrival;
            burst_reg   <= ctl.burst;
            prio_reg    <= ctl.prio;
        end
    end

    assign vld_out  = vld_reg;
    assign cand_out = cand_reg;

endmodule

@@ hdl/pps_ctrl.sv @@
module pps_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  pps_pkg::sched_cmd_t    cmd,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_wdata,
    output logic                   done,
    output pps_pkg::sched_result_t result,
    output logic                   scan_start,
    output pps_pkg::cell_ctl_t     ctl,
    input  logic                   scan_vld,
    input  pps_pkg::cand_t         scan_cand
);
    import pps_pkg::*;

    sched_state_t      state_reg, state_next;
    logic [COST_W-1:0] switch_cost_reg;
    logic [NOW_W-1:0]  now_reg;
    logic [ID_W-1:0]   last_reg;
    logic [ID_W-1:0]   count_reg;
    logic [NOW_W-1:0]  sum_wait_reg;
    logic [NOW_W-1:0]  sum_tat_reg;
    logic              done_reg;
    cand_t             best_reg;
    logic              sw_reg;
    logic [NOW_W-1:0]  tat_reg;
    logic [NOW_W-1:0]  wt_reg;
    sched_result_t     result_reg;

    logic              accept;
    logic              emit;
    logic [ID_W-1:0]   best_id;
    logic              sw_now;
    logic [NOW_W-1:0]  now_inc;
    logic [NOW_W-1:0]  now_sw;
    logic [NOW_W-1:0]  arrival_ext;
    logic [NOW_W-1:0]  burst_ext;
    logic [NOW_W-1:0]  sum_wait_new;
    logic [NOW_W-1:0]  sum_tat_new;
    logic              last_slice;

    assign accept       = start && (state_reg == ST_IDLE);
    assign best_id      = {1'b0, best_reg.slot} + ID_W'(1);
    assign sw_now       = (last_reg != '0) && (last_reg != best_id);
    assign now_inc      = sat_add(now_reg, NOW_W'(1));
    assign now_sw       = sat_add(now_reg, NOW_W'(switch_cost_reg));
    assign arrival_ext  = NOW_W'(best_reg.arrival);
    assign burst_ext    = NOW_W'(best_reg.burst);
    assign sum_wait_new = sat_add(sum_wait_reg, wt_reg);
    assign sum_tat_new  = sat_add(sum_tat_reg, tat_reg);
    assign last_slice   = (best_reg.remaining == TIME_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.action == ACT_RUN))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_vld)
                begin
                    if (scan_cand.pending && scan_cand.found)
                        state_next = ST_SWITCH;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_SWITCH: state_next = ST_TICK;
            ST_TICK:   state_next = last_slice ? ST_TAT : ST_IDLE;
            ST_TAT:    state_next = ST_WAIT;
            ST_WAIT:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = (state_reg != ST_IDLE);
        scan_start = 1'b0;
        emit       = 1'b0;
        ctl        = '0;
        ctl.now    = now_reg;
        ctl.slot   = best_reg.slot;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.slot    = cmd.slot;
                ctl.arrival = cmd.arrival_time;
                ctl.burst   = cmd.burst_length;
                ctl.prio    = cmd.prio_level;
                if (accept)
                begin
                    ctl.load   = (cmd.action == ACT_LOAD);
                    emit       = (cmd.action == ACT_LOAD);
                    scan_start = (cmd.action == ACT_RUN);
                end
            end
            ST_SCAN:
            begin
                emit = scan_vld && !(scan_cand.pending && scan_cand.found);
            end
            ST_SWITCH: ;
            ST_TICK:
            begin
                ctl.dec = 1'b1;
                emit    = !last_slice;
            end
            ST_TAT:  ;
            ST_WAIT: ;
            ST_SUM:
            begin
                emit = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            switch_cost_reg <= '0;
            now_reg         <= '0;
            last_reg        <= '0;
            count_reg       <= '0;
            sum_wait_reg    <= '0;
            sum_tat_reg     <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit;
            if (cfg_we)
                switch_cost_reg <= cfg_wdata;
            unique case (state_reg)
                ST_IDLE: ;
                ST_SCAN:
                begin
                    // idle slice: nothing arrived yet, advance by one
                    if (scan_vld && scan_cand.pending && !scan_cand.found)
                        now_reg <= now_inc;
                end
                ST_SWITCH:
                begin
                    if (sw_now)
                        now_reg <= now_sw;
                    last_reg <= best_id;
                end
                ST_TICK:
                begin
                    now_reg <= now_inc;
                end
                ST_TAT: ;
                ST_WAIT:
                begin
                    if (count_reg != COUNT_MAX)
                        count_reg <= count_reg + ID_W'(1);
                end
                ST_SUM:
                begin
                    sum_wait_reg <= sum_wait_new;
                    sum_tat_reg  <= sum_tat_new;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                result_reg.kind           <= KIND_LOAD;
                result_reg.task_id        <= {1'b0, cmd.slot} + ID_W'(1);
                result_reg.slice_end      <= now_reg;
                result_reg.switched       <= 1'b0;
                result_reg.finished       <= 1'b0;
                result_reg.turnaround     <= '0;
                result_reg.waiting        <= '0;
                result_reg.wait_sum       <= sum_wait_reg;
                result_reg.turnaround_sum <= sum_tat_reg;
                result_reg.done_count     <= count_reg;
            end
            ST_SCAN:
            begin
                best_reg                  <= scan_cand;
                result_reg.kind           <= scan_cand.pending ? KIND_IDLE : KIND_DONE;
                result_reg.task_id        <= '0;
                result_reg.slice_end      <= scan_cand.pending ? now_inc : now_reg;
                result_reg.switched       <= 1'b0;
                result_reg.finished       <= 1'b0;
                result_reg.turnaround     <= '0;
                result_reg.waiting        <= '0;
                result_reg.wait_sum       <= sum_wait_reg;
                result_reg.turnaround_sum <= sum_tat_reg;
                result_reg.done_count     <= count_reg;
            end
            ST_SWITCH:
            begin
                sw_reg <= sw_now;
            end
            ST_TICK:
            begin
                result_reg.kind           <= KIND_RAN;
                result_reg.task_id        <= best_id;
                result_reg.slice_end      <= now_inc;
                result_reg.switched       <= sw_reg;
                result_reg.finished       <= 1'b0;
                result_reg.turnaround     <= '0;
                result_reg.waiting        <= '0;
                result_reg.wait_sum       <= sum_wait_reg;
                result_reg.turnaround_sum <= sum_tat_reg;
                result_reg.done_count     <= count_reg;
            end
            ST_TAT:
            begin
                tat_reg <= (now_reg >= arrival_ext) ? (now_reg - arrival_ext) : '0;
            end
            ST_WAIT:
            begin
                wt_reg <= (tat_reg >= burst_ext) ? (tat_reg - burst_ext) : '0;
            end
            ST_SUM:
            begin
                result_reg.kind           <= KIND_RAN;
                result_reg.task_id        <= best_id;
                result_reg.slice_end      <= now_reg;
                result_reg.switched       <= sw_reg;
                result_reg.finished       <= 1'b1;
                result_reg.turnaround     <= tat_reg;
                result_reg.waiting        <= wt_reg;
                result_reg.wait_sum       <= sum_wait_new;
                result_reg.turnaround_sum <= sum_tat_new;
                result_reg.done_count     <= count_reg;
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hdl/preemptive_priority_scheduler.sv @@
// Preemptive priority scheduler with a task-switch cost. A beat with action
// load is answered in the cycle after it is taken; busy stays low, so loads
// may come back to back. A run beat holds busy high until its result is
// shown, whether no task can run, the task keeps going or it completes: the
// task table sits in a row of MAX_TASKS cells and the search for the best
// ready task moves one cell per cycle along that row. Each result is on
// result for exactly one cycle with done high; the receiver cannot stall it.
// Write switch_cost through cfg_we/cfg_wdata only while busy is low. Only the
// first sixteen cells are addressable by the slot field.
module preemptive_priority_scheduler #(
    parameter int MAX_TASKS = pps_pkg::DEFAULT_MAX_TASKS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  pps_pkg::sched_cmd_t    cmd,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_wdata,
    output logic                   done,
    output pps_pkg::sched_result_t result
);
    import pps_pkg::*;

    cell_ctl_t ctl;
    logic      scan_start;
    logic      vld_chain [MAX_TASKS+1];
    cand_t     cand_chain [MAX_TASKS+1];

    assign vld_chain[0]  = scan_start;
    assign cand_chain[0] = '0;

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        pps_cell #(
            .INDEX(i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .vld_in  (vld_chain[i]),
            .cand_in (cand_chain[i]),
            .vld_out (vld_chain[i+1]),
            .cand_out(cand_chain[i+1])
        );
    end

    pps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result),
        .scan_start(scan_start),
        .ctl       (ctl),
        .scan_vld  (vld_chain[MAX_TASKS]),
        .scan_cand (cand_chain[MAX_TASKS])
    );

endmodule

@@ tb/slice_check_pkg.sv @@
package slice_check_pkg;

    import pps_pkg::*;

    function automatic logic [NOW_W-1:0] add_capped(input logic [NOW_W-1:0] a,
                                                    input logic [NOW_W-1:0] b);
        if (a > ~b)
            return '1;
        return a + b;
    endfunction

    function automatic string show_slice(input sched_result_t r);
        return $sformatf({"kind=%0d id=%0d end=%0d sw=%0d fin=%0d tat=%0d wt=%0d ",
                          "wsum=%0d tsum=%0d cnt=%0d"},
                         r.kind, r.task_id, r.slice_end, r.switched, r.finished,
                         r.turnaround, r.waiting, r.wait_sum, r.turnaround_sum,
                         r.done_count);
    endfunction

    class slice_scoreboard;
        logic [COST_W-1:0] cost;
        logic [TIME_W-1:0] arrival_tab[SLOT_COUNT];
        logic [TIME_W-1:0] burst_tab[SLOT_COUNT];
        logic [TIME_W-1:0] left_tab[SLOT_COUNT];
        logic [PRIO_W-1:0] prio_tab[SLOT_COUNT];
        bit                loaded_tab[SLOT_COUNT];
        logic [NOW_W-1:0]  clock_now;
        logic [ID_W-1:0]   last_id;
        logic [ID_W-1:0]   finished_cnt;
        logic [NOW_W-1:0]  wait_total;
        logic [NOW_W-1:0]  tat_total;
        sched_result_t     expected_slices[$];
        int mismatches = 0;
        int checked    = 0;
        int n_loads    = 0;
        int n_ran      = 0;
        int n_switched = 0;
        int n_finished = 0;
        int n_idle     = 0;
        int n_all_done = 0;

        function new();
            cost         = '0;
            clock_now    = '0;
            last_id      = '0;
            finished_cnt = '0;
            wait_total   = '0;
            tat_total    = '0;
            foreach (loaded_tab[i])
            begin
                loaded_tab[i] = 1'b0;
                left_tab[i]   = '0;
            end
        endfunction

        // work out the result of one accepted beat and queue it
        function void note_cmd(input sched_cmd_t c);
            sched_result_t    e;
            bit               any_left;
            bit               got;
            int               pick;
            logic [NOW_W-1:0] tat;
            logic [NOW_W-1:0] wt;
            logic [ID_W-1:0]  id;

            e        = '0;
            any_left = 1'b0;
            got      = 1'b0;
            pick     = 0;
            if (c.action == ACT_LOAD)
            begin
                arrival_tab[c.slot] = c.arrival_time;
                burst_tab[c.slot]   = c.burst_length;
                left_tab[c.slot]    = c.burst_length;
                prio_tab[c.slot]    = c.prio_level;
                loaded_tab[c.slot]  = 1'b1;
                e.kind    = KIND_LOAD;
                e.task_id = ID_W'(c.slot) + ID_W'(1);
                n_loads++;
            end
            else
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (loaded_tab[i] && left_tab[i] != '0)
                    begin
                        any_left = 1'b1;
                        if (NOW_W'(arrival_tab[i]) <= clock_now &&
                            (!got || prio_tab[i] < prio_tab[pick]))
                        begin
                            pick = i;
                            got  = 1'b1;
                        end
                    end
                end
                if (!any_left)
                begin
                    e.kind = KIND_DONE;
                    n_all_done++;
                end
                else if (!got)
                begin
                    e.kind    = KIND_IDLE;
                    clock_now = add_capped(clock_now, NOW_W'(1));
                    n_idle++;
                end
                else
                begin
                    id        = ID_W'(pick + 1);
                    e.kind    = KIND_RAN;
                    e.task_id = id;
                    n_ran++;
                    if (last_id != '0 && last_id != id)
                    begin
                        clock_now  = add_capped(clock_now, NOW_W'(cost));
                        e.switched = 1'b1;
                        n_switched++;
                    end
                    last_id        = id;
                    left_tab[pick] = left_tab[pick] - TIME_W'(1);
                    clock_now      = add_capped(clock_now, NOW_W'(1));
                    if (left_tab[pick] == '0)
                    begin
                        tat = (clock_now >= NOW_W'(arrival_tab[pick])) ?
                              clock_now - NOW_W'(arrival_tab[pick]) : '0;
                        wt  = (tat >= NOW_W'(burst_tab[pick])) ?
                              tat - NOW_W'(burst_tab[pick]) : '0;
                        e.finished   = 1'b1;
                        e.turnaround = tat;
                        e.waiting    = wt;
                        wait_total   = add_capped(wait_total, wt);
                        tat_total    = add_capped(tat_total, tat);
                        if (finished_cnt != '1)
                            finished_cnt = finished_cnt + ID_W'(1);
                        n_finished++;
                    end
                end
            end
            e.slice_end      = clock_now;
            e.wait_sum       = wait_total;
            e.turnaround_sum = tat_total;
            e.done_count     = finished_cnt;
            expected_slices.push_back(e);
        endfunction

        function void check_result(input sched_result_t r);
            sched_result_t e;
            string         bad;

            bad = "";
            if (expected_slices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing pending: %s", show_slice(r));
                return;
            end
            e = expected_slices.pop_front();
            checked++;
            if (r.kind !== e.kind)                     bad = {bad, " kind"};
            if (r.task_id !== e.task_id)               bad = {bad, " task_id"};
            if (r.slice_end !== e.slice_end)           bad = {bad, " slice_end"};
            if (r.switched !== e.switched)             bad = {bad, " switched"};
            if (r.finished !== e.finished)             bad = {bad, " finished"};
            if (r.turnaround !== e.turnaround)         bad = {bad, " turnaround"};
            if (r.waiting !== e.waiting)               bad = {bad, " waiting"};
            if (r.wait_sum !== e.wait_sum)             bad = {bad, " wait_sum"};
            if (r.turnaround_sum !== e.turnaround_sum) bad = {bad, " turnaround_sum"};
            if (r.done_count !== e.done_count)         bad = {bad, " done_count"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch in%s", bad);
                    $display("  expected %s", show_slice(e));
                    $display("  actual   %s", show_slice(r));
                end
            end
        endfunction
    endclass

endpackage

@@ tb/tb_top.sv @@
module tb_top;

    import pps_pkg::*;
    import slice_check_pkg::*;

    localparam int ITEM_COUNT    = 1450;
    localparam int CALM_TAIL     = 200;
    localparam int SETTLE_CYCLES = 40;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          start;
    logic          busy;
    sched_cmd_t    cmd;
    logic          cfg_we;
    logic [7:0]    cfg_wdata;
    logic          done;
    sched_result_t result;

    slice_scoreboard sb;
    int              sent;
    int              gap_pct;
    int              cost_writes;

    preemptive_priority_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    initial
    begin
        #3000000;
        $display("timeout: %0d results still pending", sb.expected_slices.size());
        $display("FAILURE");
        $finish;
    end

    function automatic sched_cmd_t run_cmd();
        sched_cmd_t c;

        c.action       = ACT_RUN;
        c.slot         = SLOT_W'($urandom);
        c.arrival_time = TIME_W'($urandom);
        c.burst_length = TIME_W'($urandom);
        c.prio_level   = PRIO_W'($urandom);
        return c;
    endfunction

    function automatic sched_cmd_t noise_cmd();
        sched_cmd_t c;

        c        = run_cmd();
        c.action = 1'($urandom);
        return c;
    endfunction

    function automatic sched_cmd_t load_of(input int s, input int a, input int b,
                                           input int p);
        sched_cmd_t c;

        c.action       = ACT_LOAD;
        c.slot         = SLOT_W'(s);
        c.arrival_time = TIME_W'(a);
        c.burst_length = TIME_W'(b);
        c.prio_level   = PRIO_W'(p);
        return c;
    endfunction

    // arrivals mostly land just ahead of the predicted time so idle slices show up
    function automatic sched_cmd_t load_cmd();
        sched_cmd_t       c;
        int               roll;
        logic [NOW_W-1:0] soon;

        c        = run_cmd();
        c.action = ACT_LOAD;
        soon     = sb.clock_now + NOW_W'($urandom_range(0, 12));
        roll     = $urandom_range(0, 99);
        if (roll < 10)
            c.arrival_time = '0;
        else if (roll < 12)
            c.arrival_time = '1;
        else if (roll < 17)
            c.arrival_time = TIME_W'($urandom);
        else
            c.arrival_time = (soon > NOW_W'(16'hFFFF)) ? '1 : soon[TIME_W-1:0];
        roll = $urandom_range(0, 99);
        if (roll < 8)
            c.burst_length = '0;
        else if (roll < 11)
            c.burst_length = TIME_W'($urandom);
        else if (roll < 25)
            c.burst_length = TIME_W'($urandom_range(7, 40));
        else
            c.burst_length = TIME_W'($urandom_range(1, 6));
        return c;
    endfunction

    task automatic push_cmd(input sched_cmd_t c);
        if (sent < ITEM_COUNT - CALM_TAIL && $urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        cmd   <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_cmd(c);
        sent++;
    endtask

    // hold off new beats until every queued result has come back
    task automatic drain();
        start <= 1'b0;
        while (sb.expected_slices.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_cost(input logic [COST_W-1:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.cost = v;
        cost_writes++;
    endtask

    initial
    begin
        int phase;
        int slices;
        int roll;

        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        sent        = 0;
        gap_pct     = 15;
        cost_writes = 0;
        phase       = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_cost(COST_W'(3));
        push_cmd(run_cmd());                        // empty table: all finished
        push_cmd(load_of(0, 2, 2, 5));
        push_cmd(load_of(15, 0, 0, 0));             // zero burst never runs
        push_cmd(run_cmd());                        // nothing arrived yet
        push_cmd(run_cmd());
        push_cmd(run_cmd());                        // first dispatch, no switch charge
        push_cmd(load_of(3, 0, 1, 5));              // same priority as slot 0
        push_cmd(run_cmd());
        push_cmd(run_cmd());
        push_cmd(run_cmd());
        push_cmd(load_of(7, 16'hFFFF, 16'hFFFF, 8'hFF));
        push_cmd(load_of(8, 0, 3, 0));
        push_cmd(run_cmd());
        push_cmd(load_of(8, 0, 1, 8'hFF));          // reload the running task
        push_cmd(run_cmd());
        push_cmd(run_cmd());                        // only a late task is left
        push_cmd(load_of(0, 0, 2, 128));            // reload a finished slot
        push_cmd(run_cmd());
        push_cmd(run_cmd());
        push_cmd(load_of(7, 0, 2, 0));
        push_cmd(run_cmd());
        push_cmd(run_cmd());

        while (sent < ITEM_COUNT)
        begin
            phase++;
            // keep beats flowing near the end: no drain and no cost change there
            if (sent < ITEM_COUNT - CALM_TAIL)
            begin
                drain();
                case (phase % 6)
                    0:       set_cost('0);
                    1:       set_cost('1);
                    2:       set_cost(COST_W'(1));
                    3:       set_cost(COST_W'($urandom));
                    default: set_cost(COST_W'($urandom_range(0, 12)));
                endcase
            end
            gap_pct = (phase % 4 == 0) ? 0 : $urandom_range(5, 40);
            repeat ($urandom_range(1, 6)) push_cmd(load_cmd());
            slices = $urandom_range(8, 40);
            repeat (slices)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    push_cmd(load_cmd());
                else if (roll < 11)
                    push_cmd(noise_cmd());
                else
                    push_cmd(run_cmd());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d beats in %0d phases over %0d cost settings: %0d loads, %0d idle",
                 sent, phase, cost_writes, sb.n_loads, sb.n_idle);
        $display("  %0d slices run, %0d switches, %0d completions, %0d all-finished; %0d bad",
                 sb.n_ran, sb.n_switched, sb.n_finished, sb.n_all_done, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_slices.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
